[design/c2dvt_pkg.sv]
// shared types, constants and a helper function for the composite 2d vertex transform
// no dependencies; imported by composite_2d_vertex_transform_top
package c2dvt_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int DEF_FRAC_BITS   = 14;
  localparam int DEF_STAGE_COUNT = 3;
  localparam int NUM_STAGE_REGS  = 3;
  localparam int CFG_INDEX_W     = 2;
  localparam int SETTING_W       = 35;
  localparam int PARAM_W         = 16;
  localparam int KIND_W          = 3;

  // angle reduction: a + bias is never negative, then q = floor(u / 360) by reciprocal
  localparam int ANGLE_U_W     = 17;
  localparam int ANGLE_Q_W     = 8;
  localparam int ANGLE_W       = 9;
  localparam int ANGLE_SHIFT   = 24;
  localparam logic [ANGLE_U_W-1:0] ANGLE_BIAS  = 17'd33120;
  localparam logic [PARAM_W-1:0]   ANGLE_RECIP = 16'd46604;

  localparam logic [ANGLE_W-1:0] QUARTER_TURN       = 9'd90;
  localparam logic [ANGLE_W-1:0] HALF_TURN          = 9'd180;
  localparam logic [ANGLE_W-1:0] THREE_QUARTER_TURN = 9'd270;
  localparam logic [ANGLE_W-1:0] FULL_TURN          = 9'd360;

  localparam int SINE_IDX_W = 7;
  localparam int SINE_LAST  = 90;

  localparam logic [1:0] SETTLE_CYCLES = 2'd3;

  localparam longint unsigned PI_Q60    = 64'h3243F6A8885A308D;
  localparam longint unsigned SINE_STEP = PI_Q60 / 64'd180;
  localparam int SERIES_FRAC = 30;

  typedef enum logic [KIND_W-1:0] {
    KIND_TRANSLATE = 3'd0,
    KIND_SCALE     = 3'd1,
    KIND_ROTATE    = 3'd2,
    KIND_NEGATE_X  = 3'd3,
    KIND_NEGATE_Y  = 3'd4
  } stage_kind_t;

  typedef struct packed {
    logic signed [PARAM_W-1:0] param_b;
    logic signed [PARAM_W-1:0] param_a;
    logic [KIND_W-1:0]         kind;
  } stage_setting_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic                          last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic                          clipped;
    logic                          polygon_end;
  } result_t;

  typedef struct packed {
    logic                  negative;
    logic [SINE_IDX_W-1:0] index;
  } sine_fold_t;

  // map 0..359 degrees onto the first-quadrant table
  function automatic sine_fold_t fold_angle(input logic [ANGLE_W-1:0] m);
    sine_fold_t f;
    if (m <= QUARTER_TURN) begin
      f.negative = 1'b0;
      f.index    = SINE_IDX_W'(m);
    end else if (m <= HALF_TURN) begin
      f.negative = 1'b0;
      f.index    = SINE_IDX_W'(HALF_TURN - m);
    end else if (m <= THREE_QUARTER_TURN) begin
      f.negative = 1'b1;
      f.index    = SINE_IDX_W'(m - HALF_TURN);
    end else begin
      f.negative = 1'b1;
      f.index    = SINE_IDX_W'(FULL_TURN - m);
    end
    return f;
  endfunction

endpackage

[design/composite_2d_vertex_transform_top.sv]
// composite 2d vertex transform: three configurable affine stages, saturating per stage
// depends on c2dvt_pkg (types, angle and sine series constants)
//
//  channel   | handshake           | word
//  ----------+---------------------+------------------------------------------
//  vertex    | vertex_valid/_stall | vertex_x, vertex_y, last_vertex
//  result    | result_valid/_stall | out_x, out_y, clipped, polygon_end
//  cfg       | cfg_valid/cfg_ready | cfg_index selects stage setting, cfg_data
//
// one vertex word is taken per clock while vertex_stall is low; each stage is a three-register pipeline
// (multiply, combine and round, saturate); the last saturate register is the output register
// and drives result_valid.
// reset is synchronous; after reset and after every cfg write the vertex side stalls
// while each stage's angle is reduced and its sine/cosine looked up.
// a stalled result only holds back the stages behind it up to the first bubble.
module composite_2d_vertex_transform_top #(
  parameter int FRAC_BITS   = c2dvt_pkg::DEF_FRAC_BITS,
  parameter int STAGE_COUNT = c2dvt_pkg::DEF_STAGE_COUNT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                vertex_valid,
  output logic                                vertex_stall,
  input  c2dvt_pkg::vertex_t                  vertex,
  output logic                                result_valid,
  input  logic                                result_stall,
  output c2dvt_pkg::result_t                  result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [c2dvt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [c2dvt_pkg::SETTING_W-1:0]     cfg_data
);
  import c2dvt_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int FW = (FRAC_BITS + 2 > PARAM_W) ? FRAC_BITS + 2 : PARAM_W;
  localparam int PW = CW + FW;
  localparam int W  = PW + 2;
  localparam int NS = 3 * STAGE_COUNT;

  localparam logic signed [W-1:0]  ROUND_HALF = W'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [FW-1:0] SINE_ONE   = FW'(longint'(1) << FRAC_BITS);
  localparam logic signed [CW-1:0] COORD_MAX  = {1'b0, {(CW - 1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN  = {1'b1, {(CW - 1){1'b0}}};

  stage_setting_t setting [0:NUM_STAGE_REGS-1];
  logic [1:0]     settle;

  logic [NS-1:0]  vld;
  logic [NS-1:0]  rdy;
  logic [NS:0]    vchain;
  logic           vertex_take;

  logic signed [CW-1:0] st_x    [0:STAGE_COUNT];
  logic signed [CW-1:0] st_y    [0:STAGE_COUNT];
  logic                 st_clip [0:STAGE_COUNT];
  logic                 st_last [0:STAGE_COUNT];

  logic [ANGLE_U_W-1:0]   ang_u    [0:STAGE_COUNT-1];
  logic [2*ANGLE_U_W-2:0] ang_prod [0:STAGE_COUNT-1];
  logic [ANGLE_Q_W-1:0]   ang_q    [0:STAGE_COUNT-1];
  logic [ANGLE_W-1:0]     m_next   [0:STAGE_COUNT-1];
  logic [ANGLE_W-1:0]     mc_next  [0:STAGE_COUNT-1];
  logic [ANGLE_W-1:0]     ang_m    [0:STAGE_COUNT-1];
  logic [ANGLE_W-1:0]     ang_mc   [0:STAGE_COUNT-1];
  logic signed [FW-1:0]   sin_next [0:STAGE_COUNT-1];
  logic signed [FW-1:0]   cos_next [0:STAGE_COUNT-1];
  logic signed [FW-1:0]   rot_sin  [0:STAGE_COUNT-1];
  logic signed [FW-1:0]   rot_cos  [0:STAGE_COUNT-1];

  logic [FRAC_BITS:0] sine_rom [0:SINE_LAST];

  // sine of 0..90 degrees: taylor series in q30, odd terms subtracted, then rounded
  for (genvar g = 0; g <= SINE_LAST; g++) begin : g_sine
    localparam longint unsigned X   = (64'(g) * SINE_STEP) >> SERIES_FRAC;
    localparam longint unsigned X2  = (X * X) >> SERIES_FRAC;
    localparam longint unsigned T1  = ((X * X2) >> SERIES_FRAC) / 64'd6;
    localparam longint unsigned T2  = ((T1 * X2) >> SERIES_FRAC) / 64'd20;
    localparam longint unsigned T3  = ((T2 * X2) >> SERIES_FRAC) / 64'd42;
    localparam longint unsigned T4  = ((T3 * X2) >> SERIES_FRAC) / 64'd72;
    localparam longint unsigned T5  = ((T4 * X2) >> SERIES_FRAC) / 64'd110;
    localparam longint unsigned T6  = ((T5 * X2) >> SERIES_FRAC) / 64'd156;
    localparam longint unsigned T7  = ((T6 * X2) >> SERIES_FRAC) / 64'd210;
    localparam longint unsigned T8  = ((T7 * X2) >> SERIES_FRAC) / 64'd272;
    localparam longint unsigned T9  = ((T8 * X2) >> SERIES_FRAC) / 64'd342;
    localparam longint unsigned T10 = ((T9 * X2) >> SERIES_FRAC) / 64'd420;
    localparam longint unsigned T11 = ((T10 * X2) >> SERIES_FRAC) / 64'd506;
    localparam longint unsigned T12 = ((T11 * X2) >> SERIES_FRAC) / 64'd600;
    localparam longint POS = longint'(X + T2 + T4 + T6 + T8 + T10 + T12);
    localparam longint NEG = longint'(T1 + T3 + T5 + T7 + T9 + T11);
    localparam longint unsigned SUM = (POS >= NEG) ? 64'(POS - NEG) : 64'd0;
    localparam longint unsigned ENTRY =
      (SUM + (64'd1 << (SERIES_FRAC - 1 - FRAC_BITS))) >> (SERIES_FRAC - FRAC_BITS);
    assign sine_rom[g] = ENTRY[FRAC_BITS:0];
  end

  // stage settings; any cfg write restarts the angle settle count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STAGE_REGS; i++) begin
        setting[i] <= '0;
      end
      settle <= SETTLE_CYCLES;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < CFG_INDEX_W'(NUM_STAGE_REGS)) begin
          setting[cfg_index] <= stage_setting_t'(cfg_data);
        end
        settle <= SETTLE_CYCLES;
      end else if (settle != '0) begin
        settle <= settle - 2'd1;
      end
    end
  end

  assign cfg_ready = 1'b1;

  // angle path: reduce mod 360, then fold and look up sine and cosine
  always_comb begin
    logic [ANGLE_W:0] mc_sum;
    sine_fold_t       fs;
    sine_fold_t       fc;
    logic [FRAC_BITS:0] mag_s;
    logic [FRAC_BITS:0] mag_c;
    for (int s = 0; s < STAGE_COUNT; s++) begin
      ang_u[s]    = {setting[s].param_a[PARAM_W-1], setting[s].param_a} + ANGLE_BIAS;
      ang_prod[s] = (2*ANGLE_U_W-1)'(ang_u[s]) * (2*ANGLE_U_W-1)'(ANGLE_RECIP);
      m_next[s]   = ANGLE_W'(ang_u[s] - ANGLE_U_W'(ang_q[s]) * ANGLE_U_W'(FULL_TURN));
      mc_sum      = {1'b0, m_next[s]} + (ANGLE_W+1)'(QUARTER_TURN);
      if (mc_sum >= (ANGLE_W+1)'(FULL_TURN)) begin
        mc_next[s] = ANGLE_W'(mc_sum - (ANGLE_W+1)'(FULL_TURN));
      end else begin
        mc_next[s] = mc_sum[ANGLE_W-1:0];
      end
      fs    = fold_angle(ang_m[s]);
      fc    = fold_angle(ang_mc[s]);
      mag_s = sine_rom[fs.index];
      mag_c = sine_rom[fc.index];
      sin_next[s] = fs.negative ? -$signed(FW'(mag_s)) : $signed(FW'(mag_s));
      cos_next[s] = fc.negative ? -$signed(FW'(mag_c)) : $signed(FW'(mag_c));
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < STAGE_COUNT; s++) begin
      ang_q[s]   <= ang_prod[s][ANGLE_SHIFT +: ANGLE_Q_W];
      ang_m[s]   <= m_next[s];
      ang_mc[s]  <= mc_next[s];
      rot_sin[s] <= sin_next[s];
      rot_cos[s] <= cos_next[s];
    end
  end

  // pipeline control: a register may load when it is empty or its word moves on
  always_comb begin
    rdy[NS-1] = !vld[NS-1] || !result_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign vertex_stall = !rdy[0] || (settle != '0);
  assign vertex_take  = vertex_valid && !vertex_stall;
  assign vchain       = {vld, vertex_take};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vchain[k];
        end
      end
    end
  end

  assign st_x[0]    = vertex.vertex_x;
  assign st_y[0]    = vertex.vertex_y;
  assign st_clip[0] = 1'b0;
  assign st_last[0] = vertex.last_vertex;

  for (genvar i = 0; i < STAGE_COUNT; i++) begin : g_stage
    localparam int K = 3 * i;

    stage_kind_t          kind;
    logic signed [FW-1:0] f0;
    logic signed [FW-1:0] f2;
    logic signed [W-1:0]  lx;
    logic signed [W-1:0]  ly;

    logic signed [PW-1:0] prod0;
    logic signed [PW-1:0] prod1;
    logic signed [PW-1:0] prod2;
    logic signed [PW-1:0] prod3;
    logic signed [W-1:0]  lin_x;
    logic signed [W-1:0]  lin_y;
    logic                 clip1;
    logic                 last1;

    logic signed [W-1:0]  rsum_x;
    logic signed [W-1:0]  rsum_y;
    logic signed [W-1:0]  mix_x;
    logic signed [W-1:0]  mix_y;
    logic signed [W-1:0]  wide_x;
    logic signed [W-1:0]  wide_y;
    logic                 clip2;
    logic                 last2;

    logic                 over_x;
    logic                 over_y;
    logic signed [CW-1:0] sat_x;
    logic signed [CW-1:0] sat_y;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic                 clip3;
    logic                 last3;

    assign kind = stage_kind_t'(setting[i].kind);

    // multiply register: rotate uses cos/sin, scale uses the stage parameters
    always_comb begin
      if (kind == KIND_ROTATE) begin
        f0 = rot_cos[i];
        f2 = rot_cos[i];
      end else begin
        f0 = FW'(setting[i].param_a);
        f2 = FW'(setting[i].param_b);
      end
      case (kind)
        KIND_TRANSLATE: begin
          lx = W'(st_x[i]) + W'(setting[i].param_a);
          ly = W'(st_y[i]) + W'(setting[i].param_b);
        end
        KIND_NEGATE_X: begin
          lx = -W'(st_x[i]);
          ly = W'(st_y[i]);
        end
        KIND_NEGATE_Y: begin
          lx = W'(st_x[i]);
          ly = -W'(st_y[i]);
        end
        default: begin
          lx = W'(st_x[i]);
          ly = W'(st_y[i]);
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (rdy[K] && vchain[K]) begin
        prod0 <= PW'(st_x[i]) * PW'(f0);
        prod1 <= PW'(st_y[i]) * PW'(rot_sin[i]);
        prod2 <= PW'(st_y[i]) * PW'(f2);
        prod3 <= PW'(st_x[i]) * PW'(rot_sin[i]);
        lin_x <= lx;
        lin_y <= ly;
        clip1 <= st_clip[i];
        last1 <= st_last[i];
      end
    end

    // combine register: round half up and floor shift for rotate, raw products for scale
    always_comb begin
      rsum_x = W'(prod0) + W'(prod1) + ROUND_HALF;
      rsum_y = W'(prod2) - W'(prod3) + ROUND_HALF;
      case (kind)
        KIND_ROTATE: begin
          mix_x = rsum_x >>> FRAC_BITS;
          mix_y = rsum_y >>> FRAC_BITS;
        end
        KIND_SCALE: begin
          mix_x = W'(prod0);
          mix_y = W'(prod2);
        end
        default: begin
          mix_x = lin_x;
          mix_y = lin_y;
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (rdy[K+1] && vchain[K+1]) begin
        wide_x <= mix_x;
        wide_y <= mix_y;
        clip2  <= clip1;
        last2  <= last1;
      end
    end

    // saturate register: out of range when the top bits disagree with the sign
    always_comb begin
      over_x = !((&wide_x[W-1:CW-1]) || !(|wide_x[W-1:CW-1]));
      over_y = !((&wide_y[W-1:CW-1]) || !(|wide_y[W-1:CW-1]));
      if (over_x) begin
        sat_x = wide_x[W-1] ? COORD_MIN : COORD_MAX;
      end else begin
        sat_x = wide_x[CW-1:0];
      end
      if (over_y) begin
        sat_y = wide_y[W-1] ? COORD_MIN : COORD_MAX;
      end else begin
        sat_y = wide_y[CW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[K+2] && vchain[K+2]) begin
        out_x <= sat_x;
        out_y <= sat_y;
        clip3 <= clip2 || over_x || over_y;
        last3 <= last2;
      end
    end

    assign st_x[i+1]    = out_x;
    assign st_y[i+1]    = out_y;
    assign st_clip[i+1] = clip3;
    assign st_last[i+1] = last3;
  end

  assign result_valid       = vld[NS-1];
  assign result.out_x       = st_x[STAGE_COUNT];
  assign result.out_y       = st_y[STAGE_COUNT];
  assign result.clipped     = st_clip[STAGE_COUNT];
  assign result.polygon_end = st_last[STAGE_COUNT];

  // sine/cosine must be current before a vertex can reach a multiplier
  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> vertex_stall ##1 vertex_stall ##1 vertex_stall)
    else $error("vertex taken before stage angles settled");

  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (settle == '0) && !result_stall |-> !vertex_stall)
    else $error("vertex stalled with a free-running output");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    settle == '0 |-> (ang_m[0] < FULL_TURN) && (ang_mc[0] < FULL_TURN))
    else $error("angle reduction out of range");

  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    settle == '0 |-> (rot_cos[0] <= SINE_ONE) && (rot_cos[0] >= -SINE_ONE))
    else $error("cosine magnitude beyond one");

endmodule
